### hdl/sdff_pkg.sv
// ----------------------------------------------------------------------------
// sdff_pkg
// Shared constants and controller/datapath interface types for the signed
// decimal field formatter.
// ----------------------------------------------------------------------------
package sdff_pkg;

  localparam int MAX_FIELD  = 32;
  localparam int BIN_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(BIN_W);
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;
  localparam int WIDTH_W     = 7;
  localparam int PREC_W      = 7;
  localparam int FLAGS_W     = 2;
  localparam int CHAR_W      = 8;
  localparam int TOTAL_W     = 6;

  localparam int FLAG_LEFT = 0;
  localparam int FLAG_ZPAD = 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef struct packed {
    logic load;
    logic shift;
    logic size;
    logic emit;
  } sdff_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic last;
  } sdff_sts_t;

endpackage

### hdl/sdff_ctrl.sv
// ----------------------------------------------------------------------------
// sdff_ctrl
// Sequencer: accept a transaction, run the conversion, size the text and
// hand characters out one per output transaction.
// ----------------------------------------------------------------------------
module sdff_ctrl
  import sdff_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sdff_sts_t sts_i,
  output sdff_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_FIRST,
    S_SEND
  } state_e;

  state_e state_q, state_d;
  logic   tvalid_q, tvalid_d;

  always_comb begin
    state_d  = state_q;
    tvalid_d = tvalid_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.shift = 1'b1;
        if (sts_i.conv_last) begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = S_FIRST;
      end
      S_FIRST: begin
        cmd_o.emit = 1'b1;
        tvalid_d   = 1'b1;
        state_d    = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) begin
          if (sts_i.last) begin
            tvalid_d = 1'b0;
            state_d  = S_IDLE;
          end else begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      default: begin
        state_d  = S_IDLE;
        tvalid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tvalid_q <= tvalid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = tvalid_q;

endmodule

### hdl/sdff_dp.sv
// ----------------------------------------------------------------------------
// sdff_dp
// Datapath: operand capture, shift-and-add-3 binary to decimal conversion,
// segment boundaries of the text and the character output register.
// ----------------------------------------------------------------------------
module sdff_dp
  import sdff_pkg::*;
#(
  parameter int MaxField = MAX_FIELD
) (
  input  logic                  clk_i,
  input  logic [IN_TDATA_W-1:0] in_data_i,
  input  sdff_cmd_t             cmd_i,
  output sdff_sts_t             sts_o,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  char_valid_o,
  output logic                  last_char_o,
  output logic [TOTAL_W-1:0]    total_length_o
);

  localparam int LenW = $clog2(MaxField + 2);
  localparam logic [WIDTH_W-1:0] MaxW = WIDTH_W'(MaxField);
  localparam logic [PREC_W-1:0]  MaxP = PREC_W'(MaxField);

  logic [BIN_W-1:0]   value;
  logic [WIDTH_W-1:0] wraw;
  logic [PREC_W-1:0]  praw;
  logic [FLAGS_W-1:0] flags;

  assign value = in_data_i[BIN_W-1:0];
  assign wraw  = in_data_i[BIN_W +: WIDTH_W];
  assign praw  = in_data_i[BIN_W+WIDTH_W +: PREC_W];
  assign flags = in_data_i[BIN_W+WIDTH_W+PREC_W +: FLAGS_W];

  logic [BIN_W-1:0]   mag;
  logic [WIDTH_W-1:0] wabs, wsat;
  logic [PREC_W-1:0]  psat;
  logic               left_in, hasp_in;

  always_comb begin
    mag     = value[BIN_W-1] ? (BIN_W'(0) - value) : value;
    left_in = flags[FLAG_LEFT] | wraw[WIDTH_W-1];
    wabs    = wraw[WIDTH_W-1] ? (WIDTH_W'(0) - wraw) : wraw;
    wsat    = (wabs > MaxW) ? MaxW : wabs;
    hasp_in = ~praw[PREC_W-1];
    psat    = (praw > MaxP) ? MaxP : praw;
  end

  logic [BIN_W-1:0] bin_q;
  logic [BCD_W-1:0] bcd_q, bcd_adj;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q, left_q, zero_q, hasp_q;
  logic [LenW-1:0]  width_q, prec_q;

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? (bcd_q[4*k +: 4] + 4'd3)
                                                    : bcd_q[4*k +: 4];
    end
  end

  logic [NDIG_W-1:0] ndig;
  logic [LenW-1:0]   ndig_l, body, len, pad, b_lead, b_sign, b_zero, b_dig, total;

  always_comb begin
    ndig = NDIG_W'(1);
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] != 4'd0) begin
        ndig = NDIG_W'(k + 1);
      end
    end
    if (hasp_q && (prec_q == '0) && (bcd_q == '0)) begin
      ndig = '0;
    end
    ndig_l = LenW'(ndig);
    body   = (hasp_q && (prec_q > ndig_l)) ? prec_q : ndig_l;
    len    = body + LenW'(neg_q);
    pad    = (width_q > len) ? (width_q - len) : '0;
    total  = len + pad;
    b_lead = (!zero_q && !left_q) ? pad : '0;
    b_sign = b_lead + LenW'(neg_q);
    b_zero = b_sign + (zero_q ? pad : '0) + (body - ndig_l);
    b_dig  = b_zero + ndig_l;
  end

  logic [LenW-1:0] lead_q, sign_q, zeros_q, digs_q, total_q, idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q   <= mag;
      bcd_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= value[BIN_W-1];
      left_q  <= left_in;
      hasp_q  <= hasp_in;
      zero_q  <= flags[FLAG_ZPAD] & ~left_in & ~hasp_in;
      width_q <= LenW'(wsat);
      prec_q  <= hasp_in ? LenW'(psat) : '0;
    end else if (cmd_i.shift) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
      bin_q <= {bin_q[BIN_W-2:0], 1'b0};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  logic [LenW-1:0]   di_l;
  logic [3:0]        di;
  logic [3:0]        dsel;
  logic [CHAR_W-1:0] ch;
  logic [LenW:0]     idx_inc;

  always_comb begin
    di_l = digs_q - idx_q - LenW'(1);
    di   = di_l[3:0];
    dsel = 4'd0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (di == 4'(k)) begin
        dsel = bcd_q[4*k +: 4];
      end
    end
    if (idx_q < lead_q) begin
      ch = CHAR_SPACE;
    end else if (idx_q < sign_q) begin
      ch = CHAR_MINUS;
    end else if (idx_q < zeros_q) begin
      ch = CHAR_ZERO;
    end else if (idx_q < digs_q) begin
      ch = CHAR_ZERO + CHAR_W'(dsel);
    end else begin
      ch = CHAR_SPACE;
    end
    if (total_q == '0) begin
      ch = CHAR_NUL;
    end
    idx_inc = {1'b0, idx_q} + (LenW+1)'(1);
  end

  logic [CHAR_W-1:0] char_q;
  logic              cvalid_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.size) begin
      lead_q  <= b_lead;
      sign_q  <= b_sign;
      zeros_q <= b_zero;
      digs_q  <= b_dig;
      total_q <= total;
      idx_q   <= '0;
    end else if (cmd_i.emit) begin
      char_q   <= ch;
      cvalid_q <= (total_q != '0);
      last_q   <= (total_q == '0) || (idx_inc == {1'b0, total_q});
      idx_q    <= idx_inc[LenW-1:0];
    end
  end

  assign sts_o.conv_last = (cnt_q == CNT_W'(BIN_W - 1));
  assign sts_o.last      = last_q;
  assign out_char_o      = char_q;
  assign char_valid_o    = cvalid_q;
  assign last_char_o     = last_q;
  assign total_length_o  = TOTAL_W'(total_q);

endmodule

### hdl/signed_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// Sequence: an accepted input runs the 32-step shift-and-add-3 conversion,
// sizes the text and emits up to MaxField + 1 characters, one per cycle while
// m_axis_tready is high; s_axis_tready stays low until the last is accepted.
// Reset: asynchronous, active low; returns the sequencer to idle, no output.
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// Formats a signed 32-bit integer as printf %d text with width, precision,
// left-justify and zero-pad, one ASCII character per output transaction.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter
  import sdff_pkg::*;
#(
  parameter int MaxField = MAX_FIELD
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // value[31:0], field_width[38:32], precision[45:39], flags[47:46]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_char[7:0], total_length[13:8], zero[15:14]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // char_valid[0]
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  sdff_cmd_t         cmd;
  sdff_sts_t         sts;
  logic [CHAR_W-1:0] out_char;
  logic [TOTAL_W-1:0] total_length;

  sdff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdff_dp #(
    .MaxField (MaxField)
  ) u_dp (
    .clk_i          (clk_i),
    .in_data_i      (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_char_o     (out_char),
    .char_valid_o   (m_axis_tuser),
    .last_char_o    (m_axis_tlast),
    .total_length_o (total_length)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - CHAR_W - TOTAL_W)'(0), total_length, out_char};

endmodule
